// ----- design/pdcch_cce_index_calc_macros.svh -----
// assertion macros shared by the design files
`ifndef PDCCH_CCE_INDEX_CALC_MACROS_SVH
`define PDCCH_CCE_INDEX_CALC_MACROS_SVH

`ifndef ASSERT_OFF
// property checked on every clock edge outside reset
`define PCCI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition in one cycle implies a condition in the next
`define PCCI_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define PCCI_ASSERT(lbl, prop, msg)
`define PCCI_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ----- design/pcci_pkg.sv -----
package pcci_pkg;

  // field widths
  localparam int SLOT_W      = 8;
  localparam int CAND_W      = 3;
  localparam int CCE_W       = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int RNTI_W      = 16;
  localparam int CORESET_W   = 4;
  localparam int AGG_W       = 3;
  localparam int CI_W        = 3;
  localparam int NCAND_W     = 4;

  // hash arithmetic
  localparam int HASH_W          = 17;
  localparam logic [HASH_W-1:0] HASH_MOD = 17'd65537;
  localparam logic [15:0] HASH_A0 = 16'd39827;
  localparam logic [15:0] HASH_A1 = 16'd39829;
  localparam logic [15:0] HASH_A2 = 16'd39839;

  // shared divider widths
  localparam int DIV_NUM_W = 17;
  localparam int DIV_DEN_W = 9;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // parameter defaults
  localparam int DEF_MAX_CCE         = 135;
  localparam int DEF_MAX_CANDIDATES  = 8;
  localparam int DEF_SLOTS_PER_FRAME = 160;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COMMON_SPACE   = 3'd0,
    CFG_RNTI           = 3'd1,
    CFG_CORESET_ID     = 3'd2,
    CFG_NUM_CCE        = 3'd3,
    CFG_AGG_LEVEL_LOG2 = 3'd4,
    CFG_CARRIER_IND    = 3'd5,
    CFG_NUM_CANDIDATES = 3'd6
  } cfg_reg_t;

  // hash unit control
  typedef struct packed {
    logic load;
    logic step;
  } hash_ctl_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // multiplier chosen by coreset id mod 3
  function automatic logic [15:0] hash_mult(input logic [CORESET_W-1:0] id);
    logic [15:0] a;
    case (id)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: a = HASH_A0;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       a = HASH_A1;
      default:                              a = HASH_A2;
    endcase
    return a;
  endfunction

endpackage

// ----- design/pcci_intf.sv -----
// slot request channel
interface pcci_slot_if;
  import pcci_pkg::*;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot;
  modport source (output valid, output slot, input ready);
  modport sink   (input valid, input slot, output ready);
endinterface

// candidate result channel
interface pcci_result_if;
  import pcci_pkg::*;
  logic              valid;
  logic              ready;
  logic [CAND_W-1:0] candidate;
  logic [CCE_W-1:0]  first_cce;
  logic              bad_config;
  logic              last;
  modport source (output valid, output candidate, output first_cce, output bad_config,
                  output last, input ready);
  modport sink   (input valid, input candidate, input first_cce, input bad_config,
                  input last, output ready);
endinterface

// register write channel
interface pcci_cfg_if;
  import pcci_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/pcci_modmul.sv -----
module pcci_modmul (
  input  logic                      clk,
  input  logic                      rst,
  input  pcci_pkg::hash_ctl_t       ctl,
  input  logic [pcci_pkg::RNTI_W-1:0] seed,
  input  logic [15:0]               mult,
  output logic [pcci_pkg::HASH_W-1:0] y
);
  import pcci_pkg::*;

  logic [32:0]        prod;
  logic [15:0]        lo;
  logic [16:0]        hi;
  logic signed [18:0] diff;
  logic signed [18:0] fix1;
  logic signed [18:0] fix2;

  // 2^16 is -1 mod 65537, so the product folds to lo - hi
  assign prod = mult * y;
  assign lo   = prod[15:0];
  assign hi   = prod[32:16];

  always_comb begin
    diff = $signed({3'b000, lo}) - $signed({2'b00, hi});
    fix1 = (diff < 0) ? diff + $signed({2'b00, HASH_MOD}) : diff;
    fix2 = (fix1 < 0) ? fix1 + $signed({2'b00, HASH_MOD}) : fix1;
  end

  // hash register
  always_ff @(posedge clk) begin
    if (rst) begin
      y <= '0;
    end else if (ctl.load) begin
      y <= HASH_W'(seed);
    end else if (ctl.step) begin
      y <= fix2[HASH_W-1:0];
    end
  end

endmodule

// ----- design/pcci_divider.sv -----
`include "pdcch_cce_index_calc_macros.svh"

module pcci_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [pcci_pkg::DIV_NUM_W-1:0]  dividend,
  input  logic [pcci_pkg::DIV_DEN_W-1:0]  divisor,
  output pcci_pkg::div_stat_t             stat,
  output logic [pcci_pkg::DIV_NUM_W-1:0]  quotient,
  output logic [pcci_pkg::DIV_DEN_W-1:0]  remainder
);
  import pcci_pkg::*;

  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_sub;
  logic                 ge;

  // one restoring step
  always_comb begin
    rem_sh  = {rem, quo[DIV_NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den};
    ge      = rem_sh >= {1'b0, den};
  end

  // iteration, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      quo  <= '0;
      rem  <= '0;
      den  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= DIV_CNT_W'(DIV_NUM_W);
      quo  <= dividend;
      rem  <= '0;
      den  <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_NUM_W-2:0], ge};
      rem <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;
  assign remainder = rem;

  `PCCI_ASSERT(div_rem_range, done |-> (rem < den), "remainder not below divisor")
  `PCCI_ASSERT(div_done_idle, done |-> !busy, "done while still iterating")
  `PCCI_ASSERT(div_no_zero, start |-> (divisor != '0), "division by zero started")

endmodule

// ----- design/pdcch_cce_index_calc.sv -----
// channel  | modport | payload                                   | transfer
// req      | sink    | slot                                      | valid && ready
// rsp      | source  | candidate, first_cce, bad_config, last    | valid && ready
// cfg      | sink    | index, data (register write)              | valid && ready
//
// bad configuration (num_cce below level): one flagged result
// otherwise per slot: slot wrap subtracts whole frames,
// then slot mod frame + 1 hash steps (one modular multiply per cycle),
// then two passes of the shared divider per candidate
// common search space skips the slot wrap and hash steps
// synchronous reset loads register defaults; req is ready only when idle,
// and a result waits in the output register while rsp is stalled
`include "pdcch_cce_index_calc_macros.svh"

module pdcch_cce_index_calc #(
  parameter int MAX_CCE         = pcci_pkg::DEF_MAX_CCE,
  parameter int MAX_CANDIDATES  = pcci_pkg::DEF_MAX_CANDIDATES,
  parameter int SLOTS_PER_FRAME = pcci_pkg::DEF_SLOTS_PER_FRAME
) (
  input logic            clk,
  input logic            rst,
  pcci_slot_if.sink      req,
  pcci_result_if.source  rsp,
  pcci_cfg_if.sink       cfg
);
  import pcci_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b00000001,
    S_SLOT_WRAP = 8'b00000010,
    S_HASH      = 8'b00000100,
    S_OFF_GO    = 8'b00001000,
    S_OFF_WAIT  = 8'b00010000,
    S_GRP_GO    = 8'b00100000,
    S_GRP_WAIT  = 8'b01000000,
    S_EMIT      = 8'b10000000
  } state_t;

  // configuration registers
  logic                 common_space;
  logic [RNTI_W-1:0]    rnti;
  logic [CORESET_W-1:0] coreset_id;
  logic [CCE_W-1:0]     num_cce;
  logic [AGG_W-1:0]     agg_level_log2;
  logic [CI_W-1:0]      carrier_ind;
  logic [NCAND_W-1:0]   num_candidates;

  // sequencer registers
  state_t               state;
  logic [SLOT_W-1:0]    slot_q;
  logic [SLOT_W-1:0]    hash_cnt;
  logic [NCAND_W-1:0]   m;
  logic [11:0]          mn;
  logic [CCE_W-1:0]     off;
  logic [CCE_W-1:0]     start_cce;
  logic                 bad;

  // output register
  logic                 rsp_valid;
  logic [CAND_W-1:0]    rsp_cand;
  logic [CCE_W-1:0]     rsp_first;
  logic                 rsp_bad;
  logic                 rsp_last;

  // derived values
  logic [AGG_W-1:0]     lg;
  logic [CCE_W-1:0]     n;
  logic [NCAND_W-1:0]   m_cnt;
  logic [CCE_W-1:0]     groups;
  logic                 too_few;
  logic                 slot_ge;
  logic                 req_fire;
  logic                 emit_load;
  logic                 emit_last;

  // shared units
  hash_ctl_t            hash_ctl;
  logic [HASH_W-1:0]    hash_y;
  logic [HASH_W-1:0]    y_used;
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  div_stat_t            div_stat;
  logic [DIV_NUM_W-1:0] div_quo;
  logic [DIV_DEN_W-1:0] div_rem;

  // clamp the configuration
  always_comb begin
    lg      = (agg_level_log2 > AGG_W'(4)) ? AGG_W'(4) : agg_level_log2;
    n       = ({1'b0, num_cce} > 9'(MAX_CCE)) ? CCE_W'(MAX_CCE) : num_cce;
    m_cnt   = ({1'b0, num_candidates} > 5'(MAX_CANDIDATES)) ?
              NCAND_W'(MAX_CANDIDATES) : num_candidates;
    groups  = n >> lg;
    too_few = {1'b0, n} < (9'd1 << lg);
    y_used  = common_space ? '0 : hash_y;
  end

  // slot still at or beyond one frame
  assign slot_ge = {2'b00, slot_q} >= 10'(SLOTS_PER_FRAME);

  assign req_fire  = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign emit_load = (state == S_EMIT) && (!rsp_valid || rsp.ready);
  assign emit_last = bad || (({1'b0, m} + 5'd1) == {1'b0, m_cnt});

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      common_space   <= 1'b1;
      rnti           <= 16'd4096;
      coreset_id     <= '0;
      num_cce        <= 8'd16;
      agg_level_log2 <= 3'd2;
      carrier_ind    <= '0;
      num_candidates <= 4'd2;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_COMMON_SPACE:   common_space   <= cfg.data[0];
        CFG_RNTI:           rnti           <= cfg.data[RNTI_W-1:0];
        CFG_CORESET_ID:     coreset_id     <= cfg.data[CORESET_W-1:0];
        CFG_NUM_CCE:        num_cce        <= cfg.data[CCE_W-1:0];
        CFG_AGG_LEVEL_LOG2: agg_level_log2 <= cfg.data[AGG_W-1:0];
        CFG_CARRIER_IND:    carrier_ind    <= cfg.data[CI_W-1:0];
        CFG_NUM_CANDIDATES: num_candidates <= cfg.data[NCAND_W-1:0];
        default: ;
      endcase
    end
  end

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      S_OFF_GO: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_W'(mn >> lg);
        div_den   = DIV_DEN_W'(m_cnt);
      end
      S_GRP_GO: begin
        div_start = 1'b1;
        div_num   = y_used + DIV_NUM_W'(off) + DIV_NUM_W'(carrier_ind);
        div_den   = DIV_DEN_W'(groups);
      end
      default: ;
    endcase
  end

  // hash unit control
  always_comb begin
    hash_ctl.load = (state == S_SLOT_WRAP) && !slot_ge;
    hash_ctl.step = (state == S_HASH);
  end

  pcci_modmul u_modmul (
    .clk  (clk),
    .rst  (rst),
    .ctl  (hash_ctl),
    .seed (rnti),
    .mult (hash_mult(coreset_id)),
    .y    (hash_y)
  );

  pcci_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_num),
    .divisor   (div_den),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      slot_q    <= '0;
      hash_cnt  <= '0;
      m         <= '0;
      mn        <= '0;
      off       <= '0;
      start_cce <= '0;
      bad       <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            slot_q    <= req.slot;
            m         <= '0;
            mn        <= '0;
            start_cce <= '0;
            if (too_few) begin
              bad   <= 1'b1;
              state <= S_EMIT;
            end else if (m_cnt != '0) begin
              bad   <= 1'b0;
              state <= common_space ? S_OFF_GO : S_SLOT_WRAP;
            end
          end
        end
        // subtract whole frames, then seed the hash
        S_SLOT_WRAP: begin
          if (slot_ge) begin
            slot_q <= slot_q - SLOT_W'(SLOTS_PER_FRAME);
          end else begin
            hash_cnt <= slot_q;
            state    <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_cnt == '0) begin
            state <= S_OFF_GO;
          end else begin
            hash_cnt <= hash_cnt - 1'b1;
          end
        end
        S_OFF_GO: state <= S_OFF_WAIT;
        S_OFF_WAIT: begin
          if (div_stat.done) begin
            off   <= div_quo[CCE_W-1:0];
            state <= S_GRP_GO;
          end
        end
        S_GRP_GO: state <= S_GRP_WAIT;
        S_GRP_WAIT: begin
          if (div_stat.done) begin
            start_cce <= CCE_W'(13'(div_rem) << lg);
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_load) begin
            if (emit_last) begin
              state <= S_IDLE;
            end else begin
              m     <= m + 1'b1;
              mn    <= mn + 12'(n);
              state <= S_OFF_GO;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      rsp_cand  <= '0;
      rsp_first <= '0;
      rsp_bad   <= 1'b0;
      rsp_last  <= 1'b0;
    end else if (emit_load) begin
      rsp_valid <= 1'b1;
      rsp_cand  <= m[CAND_W-1:0];
      rsp_first <= start_cce;
      rsp_bad   <= bad;
      rsp_last  <= emit_last;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.candidate  = rsp_cand;
  assign rsp.first_cce  = rsp_first;
  assign rsp.bad_config = rsp_bad;
  assign rsp.last       = rsp_last;

  `PCCI_ASSERT(bad_shape, rsp_bad |-> (rsp_last && {rsp_cand, rsp_first} == '0), "bad result")
  `PCCI_ASSERT_NEXT(last_to_idle, emit_load && emit_last, state == S_IDLE, "not idle after last")
  `PCCI_ASSERT(idle_div_quiet, (state == S_IDLE) |-> !div_stat.busy, "divider busy while idle")

endmodule

// ----- sim/pdcch_cce_index_calc_tb.sv -----
module pdcch_cce_index_calc_tb;
  import pcci_pkg::*;

  localparam int CYCLE_LIMIT  = 1_500_000;
  // covers slot wrap, up to 160 hash steps and eight candidates
  localparam int DRAIN_CYCLES = 600;
  localparam int RANDOM_ITEMS = 400;
  localparam int MAX_GAP      = 14;
  // index with no register behind it
  localparam cfg_reg_t CFG_NO_REG = cfg_reg_t'(3'd7);
  localparam int REG_W [7] = '{1, RNTI_W, CORESET_W, CCE_W, AGG_W, CI_W, NCAND_W};

  typedef struct packed {
    logic [CAND_W-1:0] candidate;
    logic [CCE_W-1:0]  first_cce;
    logic              bad_config;
    logic              last;
  } cand_t;

  // register shadow, cce start predictor and queue of expected candidates
  class cce_scoreboard;
    logic                 common_space;
    logic [RNTI_W-1:0]    rnti;
    logic [CORESET_W-1:0] coreset_id;
    logic [CCE_W-1:0]     num_cce;
    logic [AGG_W-1:0]     agg_log2;
    logic [CI_W-1:0]      carrier_ind;
    logic [NCAND_W-1:0]   num_cand;
    cand_t                pending_cands[$];
    int                   err_cnt;

    function new();
      common_space = 1'b1;
      rnti         = 16'd4096;
      coreset_id   = '0;
      num_cce      = 8'd16;
      agg_log2     = 3'd2;
      carrier_ind  = '0;
      num_cand     = 4'd2;
      err_cnt      = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_COMMON_SPACE:   common_space = value[0];
        CFG_RNTI:           rnti         = value[RNTI_W-1:0];
        CFG_CORESET_ID:     coreset_id   = value[CORESET_W-1:0];
        CFG_NUM_CCE:        num_cce      = value[CCE_W-1:0];
        CFG_AGG_LEVEL_LOG2: agg_log2     = value[AGG_W-1:0];
        CFG_CARRIER_IND:    carrier_ind  = value[CI_W-1:0];
        CFG_NUM_CANDIDATES: num_cand     = value[NCAND_W-1:0];
        default: ;
      endcase
    endfunction

    // expected candidate starts for one accepted slot
    function void note_slot(logic [SLOT_W-1:0] slot_in);
      int unsigned     slot_mod, lg, lvl, n_cce, n_cand, groups, offs;
      longint unsigned y, mult;
      cand_t           r;
      slot_mod = slot_in % DEF_SLOTS_PER_FRAME;
      lg       = (agg_log2 > 4) ? 4 : agg_log2;
      lvl      = 1 << lg;
      n_cce    = (num_cce > DEF_MAX_CCE) ? DEF_MAX_CCE : num_cce;
      n_cand   = (num_cand > DEF_MAX_CANDIDATES) ? DEF_MAX_CANDIDATES : num_cand;
      // coreset too small for the level: single flagged result
      if (n_cce < lvl) begin
        r = cand_t'{candidate: '0, first_cce: '0, bad_config: 1'b1, last: 1'b1};
        pending_cands.push_back(r);
        return;
      end
      // hash value, zero in common space
      y = 0;
      if (!common_space) begin
        case (coreset_id % 3)
          0:       mult = HASH_A0;
          1:       mult = HASH_A1;
          default: mult = HASH_A2;
        endcase
        y = rnti;
        for (int unsigned k = 0; k <= slot_mod; k++) y = (mult * y) % HASH_MOD;
      end
      groups = n_cce / lvl;
      for (int unsigned m = 0; m < n_cand; m++) begin
        offs         = (m * n_cce) / (lvl * n_cand);
        r.candidate  = m[CAND_W-1:0];
        r.first_cce  = CCE_W'(lvl * ((y + offs + carrier_ind) % groups));
        r.bad_config = 1'b0;
        r.last       = (m + 1 == n_cand);
        pending_cands.push_back(r);
      end
    endfunction

    function void check_result(logic [CAND_W-1:0] cand, logic [CCE_W-1:0] cce,
                               logic bad, logic lst);
      cand_t want;
      if (pending_cands.size() == 0) begin
        $error("unexpected result: candidate %0d first_cce %0d bad_config %0b last %0b",
               cand, cce, bad, lst);
        err_cnt++;
        return;
      end
      want = pending_cands.pop_front();
      if (cand !== want.candidate) begin
        $error("candidate: expected %0d, actual %0d", want.candidate, cand);
        err_cnt++;
      end
      if (cce !== want.first_cce) begin
        $error("first_cce: expected %0d, actual %0d", want.first_cce, cce);
        err_cnt++;
      end
      if (bad !== want.bad_config) begin
        $error("bad_config: expected %0b, actual %0b", want.bad_config, bad);
        err_cnt++;
      end
      if (lst !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, lst);
        err_cnt++;
      end
    endfunction
  endclass

  logic          clk;
  logic          rst;
  int unsigned   cycle_cnt = 0;
  bit            req_gapless = 1'b0;
  bit            rsp_gapless = 1'b0;
  cce_scoreboard sb;

  pcci_slot_if   req_if ();
  pcci_result_if rsp_if ();
  pcci_cfg_if    cfg_if ();

  pdcch_cce_index_calc u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst === 1'b0 && rsp_if.valid && rsp_if.ready)
      sb.check_result(rsp_if.candidate, rsp_if.first_cce, rsp_if.bad_config, rsp_if.last);
  end

  // result sink with random stalls
  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall = rsp_gapless ? 0 : $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 24) == 0) rsp_gapless = !rsp_gapless;
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_if.valid) @(posedge clk);
    end
  end

  // one slot request transfer; valid stays high for a back-to-back request
  task automatic send_slot(input logic [SLOT_W-1:0] s);
    int gap;
    gap = req_gapless ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.slot  <= s;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_slot(s);
  endtask

  // one register write transfer; caller drops valid after the batch
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  // drain results, then let a slot with no candidates finish
  task automatic settle();
    req_if.valid <= 1'b0;
    while (sb.pending_cands.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random register set, sometimes with junk above the field width
  task automatic random_config();
    logic [CFG_DATA_W-1:0] v;
    for (int r = 0; r < 7; r++) begin
      if ($urandom_range(0, 3) == 0) continue;
      case (cfg_reg_t'(r))
        CFG_COMMON_SPACE:   v = CFG_DATA_W'($urandom_range(0, 3) == 0);
        CFG_RNTI:           v = CFG_DATA_W'($urandom);
        CFG_CORESET_ID:     v = CFG_DATA_W'($urandom_range(0, 15));
        CFG_NUM_CCE: begin
          case ($urandom_range(0, 9))
            0:       v = CFG_DATA_W'($urandom_range(136, 255));
            1:       v = CFG_DATA_W'($urandom_range(0, 15));
            default: v = CFG_DATA_W'($urandom_range(1, DEF_MAX_CCE));
          endcase
        end
        CFG_AGG_LEVEL_LOG2: v = CFG_DATA_W'(($urandom_range(0, 7) == 0) ?
                                            $urandom_range(5, 7) : $urandom_range(0, 4));
        CFG_CARRIER_IND:    v = CFG_DATA_W'($urandom_range(0, 7));
        CFG_NUM_CANDIDATES: begin
          case ($urandom_range(0, 11))
            0:       v = '0;
            1:       v = CFG_DATA_W'($urandom_range(9, 15));
            default: v = CFG_DATA_W'($urandom_range(1, DEF_MAX_CANDIDATES));
          endcase
        end
        default: v = '0;
      endcase
      if ($urandom_range(0, 3) == 0) v = v | (CFG_DATA_W'($urandom) << REG_W[r]);
      write_reg(cfg_reg_t'(r), v);
    end
    if ($urandom_range(0, 7) == 0) write_reg(CFG_NO_REG, CFG_DATA_W'($urandom));
    cfg_if.valid <= 1'b0;
  endtask

  // main sequence
  initial begin
    int items_sent;
    int burst;
    sb = new();
    rst          <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.slot  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_COMMON_SPACE;
    cfg_if.data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: common space, slot ignored
    send_slot(8'd0);
    send_slot(8'd255);

    // ue-specific, widest rnti, coreset id mod 3 = 2, level one, eight candidates
    settle();
    write_reg(CFG_COMMON_SPACE, 16'd0);
    write_reg(CFG_RNTI, 16'hFFFF);
    write_reg(CFG_CORESET_ID, 16'd11);
    write_reg(CFG_NUM_CCE, 16'd135);
    write_reg(CFG_AGG_LEVEL_LOG2, 16'd0);
    write_reg(CFG_CARRIER_IND, 16'd7);
    write_reg(CFG_NUM_CANDIDATES, 16'd8);
    cfg_if.valid <= 1'b0;
    send_slot(8'd0);
    send_slot(8'd159);
    send_slot(8'd160);
    send_slot(8'd255);

    // saturation of cce count, level and candidate count; zero rnti
    settle();
    write_reg(CFG_RNTI, 16'd0);
    write_reg(CFG_CORESET_ID, 16'd1);
    write_reg(CFG_NUM_CCE, 16'd255);
    write_reg(CFG_AGG_LEVEL_LOG2, 16'd7);
    write_reg(CFG_CARRIER_IND, 16'd0);
    write_reg(CFG_NUM_CANDIDATES, 16'd15);
    cfg_if.valid <= 1'b0;
    send_slot(8'd1);
    send_slot(8'd77);

    // too few cces, with no candidates as well
    settle();
    write_reg(CFG_NUM_CCE, 16'd1);
    write_reg(CFG_AGG_LEVEL_LOG2, 16'd4);
    write_reg(CFG_NUM_CANDIDATES, 16'd0);
    cfg_if.valid <= 1'b0;
    send_slot(8'd5);

    // no candidates on a valid coreset: nothing comes back
    settle();
    write_reg(CFG_NUM_CCE, 16'd16);
    write_reg(CFG_AGG_LEVEL_LOG2, 16'd1);
    cfg_if.valid <= 1'b0;
    send_slot(8'd10);
    send_slot(8'd11);

    // coreset exactly one group wide, first multiplier, junk above field widths
    settle();
    write_reg(CFG_RNTI, 16'd4096);
    write_reg(CFG_CORESET_ID, 16'hFFF0);
    write_reg(CFG_NUM_CCE, 16'hAB08);
    write_reg(CFG_AGG_LEVEL_LOG2, 16'hFFFB);
    write_reg(CFG_NUM_CANDIDATES, 16'h0F03);
    write_reg(CFG_NO_REG, 16'h5A5A);
    cfg_if.valid <= 1'b0;
    send_slot(8'd7);
    send_slot(8'd100);

    // zero cces, coreset id at the top of its range
    settle();
    write_reg(CFG_CORESET_ID, 16'd15);
    write_reg(CFG_NUM_CCE, 16'd0);
    cfg_if.valid <= 1'b0;
    send_slot(8'd3);

    // random phases
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      settle();
      random_config();
      req_gapless = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(4, 24);
      repeat (burst) begin
        send_slot(SLOT_W'(($urandom_range(0, 7) == 0) ? $urandom_range(160, 255)
                                              : $urandom_range(0, DEF_SLOTS_PER_FRAME - 1)));
        items_sent++;
      end
    end

    settle();
    if (sb.err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/pcci_pkg.sv
design/pcci_intf.sv
design/pcci_modmul.sv
design/pcci_divider.sv
design/pdcch_cce_index_calc.sv
sim/pdcch_cce_index_calc_tb.sv
